// ----- hw/rtl/lbcd_pkg.sv -----
`timescale 1ns / 1ps
package lbcd_pkg;

	// Default sizes for the top-level parameters.
	localparam int DEF_NUM_BLOCKS  = 64;
	localparam int DEF_DIRTY_DEPTH = 32;

	// Configuration port geometry: two registers, each read as a 32-bit word, at byte addresses 0 and 4.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// Register indexes, taken from paddr[2].
	localparam logic REG_EAGER  = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	// Operation codes.
	localparam logic [3:0] OP_RD_FAULT = 4'd0;
	localparam logic [3:0] OP_WR_FAULT = 4'd1;
	localparam logic [3:0] OP_ACQUIRE  = 4'd2;
	localparam logic [3:0] OP_RELEASE  = 4'd3;
	localparam logic [3:0] OP_REL_ALL  = 4'd4;
	localparam logic [3:0] OP_RELD_ALL = 4'd5;
	localparam logic [3:0] OP_MAP      = 4'd6;
	localparam logic [3:0] OP_UNMAP    = 4'd7;
	localparam logic [3:0] OP_TO_HOST  = 4'd8;

	// Coherence marks.
	localparam logic [1:0] MK_INV   = 2'd0;
	localparam logic [1:0] MK_RO    = 2'd1;
	localparam logic [1:0] MK_DIRTY = 2'd2;
	localparam logic [1:0] MK_HOST  = 2'd3;

	// Host protection codes.
	localparam logic [1:0] PR_NONE = 2'd0;
	localparam logic [1:0] PR_READ = 2'd1;
	localparam logic [1:0] PR_RW   = 2'd2;

	// Copy actions.
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_TO_HOST = 2'd1;
	localparam logic [1:0] ACT_TO_ACC  = 2'd2;

	typedef struct packed {
		logic [3:0] opcode;
		logic [5:0] block_index;
		logic       acquire_writable;
	} lbcd_in_t;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] target_block;
		logic [1:0] new_state;
		logic [1:0] protection;
		logic       error;
		logic       last;
	} lbcd_out_t;

	typedef struct packed {
		logic       eager_mode;
		logic [7:0] roll_threshold;
	} lbcd_cfg_t;

	// Protection implied by a mark when an operation leaves it alone.
	function automatic logic [1:0] prot_of(logic [1:0] mark);
		logic [1:0] p;
		case (mark)
			MK_INV:  p = PR_NONE;
			MK_RO:   p = PR_READ;
			default: p = PR_RW;
		endcase
		return p;
	endfunction

endpackage

// ----- hw/rtl/lazy_block_coherence_dirty_list.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data   (lbcd_in_t)
// out       output     out_valid / out_ready   out_data  (lbcd_out_t)
// config    input      psel/penable/pready     paddr, pwdata, prdata
//
// One transaction at a time: after the accept, the S_MOD state reduces the index and
// issues the mark and counter reads, staying there while a multiple of NUM_BLOCKS remains
// to strip; S_RD takes the read data, then S_EXEC gives the result. Each block evicted
// from the dirty list passes through S_EV0 to S_EV3, a list insertion through S_PUSH, and
// each list entry searched or shifted by a removal through S_RM0/S_RM1 or S_SH0/S_SH1.
// Reset clears marks to host-only and counters to zero through valid bits at once.
// A stalled result holds the sequencer in place; the last result may wait while
// the next input transaction is taken.
module lazy_block_coherence_dirty_list #(
	parameter int NUM_BLOCKS  = lbcd_pkg::DEF_NUM_BLOCKS,
	parameter int DIRTY_DEPTH = lbcd_pkg::DEF_DIRTY_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lbcd_pkg::lbcd_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lbcd_pkg::lbcd_out_t           out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lbcd_pkg::CFG_AW-1:0]   paddr,
	input  logic [lbcd_pkg::CFG_DW-1:0]   pwdata,
	output logic [lbcd_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready
);
	import lbcd_pkg::*;

	lbcd_cfg_t cfg;

	// Configuration registers.
	lbcd_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Coherence sequencer with mark, counter and dirty-list storage.
	lbcd_seq #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.DIRTY_DEPTH (DIRTY_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg       (cfg)
	);

endmodule

// ----- hw/rtl/lbcd_apb.sv -----
`timescale 1ns / 1ps
module lbcd_apb (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lbcd_pkg::CFG_AW-1:0]        paddr,
	input  logic [lbcd_pkg::CFG_DW-1:0]        pwdata,
	output logic [lbcd_pkg::CFG_DW-1:0]        prdata,
	output logic                               pready,
	output lbcd_pkg::lbcd_cfg_t                cfg
);
	import lbcd_pkg::*;

	logic       eager_q;
	logic [7:0] thresh_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eager_q  <= 1'b0;
			thresh_q <= 8'd2;
		end else if (wr_en) begin
			case (paddr[2])
				REG_EAGER:  eager_q  <= pwdata[0];
				REG_THRESH: thresh_q <= pwdata[7:0];
				default:    eager_q  <= eager_q;
			endcase
		end
	end

	// Read data mux; a nonzero byte offset in the low address bits reads as zero.
	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_EAGER:  prdata = {{(CFG_DW-1){1'b0}}, eager_q};
			REG_THRESH: prdata = {{(CFG_DW-8){1'b0}}, thresh_q};
			default:    prdata = '0;
		endcase
		if (paddr[1:0] != 2'b00) begin
			prdata = '0;
		end
	end

	assign cfg.eager_mode     = eager_q;
	assign cfg.roll_threshold = thresh_q;

endmodule

// ----- hw/rtl/lbcd_seq.sv -----
`timescale 1ns / 1ps
module lbcd_seq #(
	parameter int NUM_BLOCKS  = lbcd_pkg::DEF_NUM_BLOCKS,
	parameter int DIRTY_DEPTH = lbcd_pkg::DEF_DIRTY_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lbcd_pkg::lbcd_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lbcd_pkg::lbcd_out_t  out_data,
	input  lbcd_pkg::lbcd_cfg_t  cfg
);
	import lbcd_pkg::*;

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int PW = (DIRTY_DEPTH > 1) ? $clog2(DIRTY_DEPTH) : 1;
	localparam int CW = $clog2(DIRTY_DEPTH + 1);
	localparam logic [5:0]    NB_MOD  = 6'(NUM_BLOCKS % 64);
	localparam logic [CW-1:0] DEPTH_C = CW'(DIRTY_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_RD, S_EXEC, S_PUSH,
		S_EV0, S_EV1, S_EV2, S_EV3,
		S_RM0, S_RM1, S_SH0, S_SH1
	} state_t;

	// Position in the circular dirty list, relative to its head.
	function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] h, logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(DIRTY_DEPTH)) begin
			s = s - (CW+1)'(DIRTY_DEPTH);
		end
		return PW'(s);
	endfunction

	state_t          state_q;
	logic [3:0]      op_q;
	logic [5:0]      blk_q;
	logic            wr_q;
	logic [1:0]      m_q;
	logic [7:0]      wfc_q;
	logic [CW-1:0]   dcount_q;
	logic [CW-1:0]   lim_q;
	logic [PW-1:0]   head_q;
	logic [CW-1:0]   idx_q;
	logic            push_pend_q;
	logic [5:0]      ev_blk_q;
	logic [1:0]      ev_m_q;
	logic            out_valid_q;
	lbcd_out_t       out_q;

	// Storage: marks and fault counters with valid bits, dirty list without.
	logic [1:0]            mark_mem [NUM_BLOCKS];
	logic [7:0]            cnt_mem  [NUM_BLOCKS];
	logic [5:0]            fifo_mem [DIRTY_DEPTH];
	logic [NUM_BLOCKS-1:0] mark_vld_q;
	logic [NUM_BLOCKS-1:0] cnt_vld_q;
	logic [1:0]            mark_rd_q;
	logic                  mvld_rd_q;
	logic [7:0]            cnt_rd_q;
	logic                  cvld_rd_q;
	logic [5:0]            fifo_rd_q;

	logic            mark_we;
	logic [AW-1:0]   mark_wa;
	logic [1:0]      mark_wd;
	logic [AW-1:0]   mark_ra;
	logic            cnt_we;
	logic [7:0]      cnt_wd;
	logic            fifo_we;
	logic [PW-1:0]   fifo_wa;
	logic [5:0]      fifo_wd;
	logic [PW-1:0]   fifo_ra;

	logic            emit;
	lbcd_out_t       out_d;
	logic            out_free;
	logic [1:0]      rd_mark;
	logic [7:0]      rd_cnt;
	logic [7:0]      cnt_new;
	logic            trig;
	logic [CW-1:0]   lim_inc;
	logic            add;
	logic            full;
	logic            more_add;
	logic [CW-1:0]   floor_c;
	logic            ev_last;
	logic            shrink;
	logic [CW-1:0]   idx_nxt;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign rd_mark = mvld_rd_q ? mark_rd_q : MK_HOST;
	assign rd_cnt  = cvld_rd_q ? cnt_rd_q : 8'd0;
	assign idx_nxt = idx_q + CW'(1);

	// Decisions shared by the result, the writes and the next state.
	always_comb begin
		cnt_new = wfc_q;
		if (op_q == OP_WR_FAULT && wfc_q != 8'hFF) begin
			cnt_new = wfc_q + 8'd1;
		end
		trig    = cfg.eager_mode && (cnt_new >= cfg.roll_threshold);
		lim_inc = (trig && lim_q < DEPTH_C) ? lim_q + CW'(1) : lim_q;
		add     = (op_q == OP_WR_FAULT && m_q != MK_DIRTY) ||
		          (op_q == OP_MAP && m_q == MK_HOST);
		full    = dcount_q >= DEPTH_C;
		more_add = full ||
		           (cfg.eager_mode && ((CW+1)'(dcount_q) + (CW+1)'(1) > (CW+1)'(lim_inc)));
		floor_c = (op_q == OP_REL_ALL) ? '0 : lim_q;
		ev_last = push_pend_q ? !(cfg.eager_mode && DEPTH_C > lim_q) : (dcount_q <= floor_c);
		shrink  = cfg.eager_mode && dcount_q < lim_q && lim_q > CW'(1);
	end

	// Result, memory writes and read addresses for the current step.
	always_comb begin
		emit    = 1'b0;
		out_d.action       = ACT_NONE;
		out_d.target_block = blk_q;
		out_d.new_state    = m_q;
		out_d.protection   = prot_of(m_q);
		out_d.error        = 1'b0;
		out_d.last         = 1'b1;
		mark_we = 1'b0;
		mark_wa = AW'(blk_q);
		mark_wd = m_q;
		mark_ra = AW'(blk_q);
		cnt_we  = 1'b0;
		cnt_wd  = cnt_new;
		fifo_we = 1'b0;
		fifo_wa = wrap_add(head_q, dcount_q);
		fifo_wd = blk_q;
		fifo_ra = head_q;
		case (state_q)
			S_EXEC: begin
				if (out_free) begin
					emit = 1'b1;
					case (op_q)
						OP_RD_FAULT: begin
							if (m_q == MK_INV) begin
								mark_we = 1'b1;
								mark_wd = MK_RO;
								out_d.action     = ACT_TO_HOST;
								out_d.new_state  = MK_RO;
								out_d.protection = PR_READ;
							end else if (m_q != MK_HOST) begin
								out_d.protection = PR_READ;
							end
						end
						OP_WR_FAULT: begin
							cnt_we = 1'b1;
							cnt_wd = (add && trig) ? 8'd0 : cnt_new;
							if (m_q != MK_DIRTY) begin
								mark_we = 1'b1;
								mark_wd = MK_DIRTY;
								out_d.action    = (m_q == MK_INV) ? ACT_TO_HOST : ACT_NONE;
								out_d.new_state = MK_DIRTY;
								out_d.protection = PR_RW;
								out_d.last      = !more_add;
							end
						end
						OP_ACQUIRE: begin
							if ((m_q == MK_INV || m_q == MK_RO) && wr_q) begin
								mark_we = 1'b1;
								mark_wd = MK_INV;
								out_d.new_state  = MK_INV;
								out_d.protection = PR_NONE;
							end
						end
						OP_RELEASE: begin
							if (m_q == MK_DIRTY) begin
								mark_we = 1'b1;
								mark_wd = MK_RO;
								out_d.action     = ACT_TO_ACC;
								out_d.new_state  = MK_RO;
								out_d.protection = PR_READ;
							end
						end
						OP_REL_ALL: begin
							emit = (dcount_q == '0);
						end
						OP_MAP: begin
							if (m_q == MK_HOST) begin
								mark_we = 1'b1;
								mark_wd = MK_DIRTY;
								cnt_we  = trig;
								cnt_wd  = 8'd0;
								out_d.new_state  = MK_DIRTY;
								out_d.protection = PR_RW;
								out_d.last       = !more_add;
							end else begin
								out_d.error = 1'b1;
							end
						end
						OP_UNMAP: begin
							mark_we = 1'b1;
							mark_wd = MK_HOST;
							out_d.action     = (m_q == MK_INV) ? ACT_TO_HOST : ACT_NONE;
							out_d.new_state  = MK_HOST;
							out_d.protection = PR_RW;
						end
						OP_TO_HOST: begin
							if (m_q == MK_INV) begin
								mark_we = 1'b1;
								mark_wd = MK_RO;
								out_d.action     = ACT_TO_HOST;
								out_d.new_state  = MK_RO;
								out_d.protection = PR_READ;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_EV1: begin
				mark_ra = AW'(fifo_rd_q);
			end
			S_EV3: begin
				if (out_free) begin
					emit = 1'b1;
					mark_wa = AW'(ev_blk_q);
					out_d.target_block = ev_blk_q;
					out_d.last         = ev_last;
					if (ev_m_q == MK_DIRTY) begin
						mark_we = 1'b1;
						mark_wd = MK_RO;
						out_d.action     = ACT_TO_ACC;
						out_d.new_state  = MK_RO;
						out_d.protection = PR_READ;
					end else begin
						out_d.new_state  = ev_m_q;
						out_d.protection = prot_of(ev_m_q);
					end
				end
			end
			S_PUSH: begin
				fifo_we = 1'b1;
			end
			S_RM0: begin
				fifo_ra = wrap_add(head_q, idx_q);
			end
			S_SH0: begin
				fifo_ra = wrap_add(head_q, idx_nxt);
			end
			S_SH1: begin
				fifo_we = 1'b1;
				fifo_wa = wrap_add(head_q, idx_q);
				fifo_wd = fifo_rd_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Memory ports, read data registered.
	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		if (cnt_we) begin
			cnt_mem[AW'(blk_q)] <= cnt_wd;
		end
		if (fifo_we) begin
			fifo_mem[fifo_wa] <= fifo_wd;
		end
		mark_rd_q <= mark_mem[mark_ra];
		mvld_rd_q <= mark_vld_q[mark_ra];
		cnt_rd_q  <= cnt_mem[AW'(blk_q)];
		cvld_rd_q <= cnt_vld_q[AW'(blk_q)];
		fifo_rd_q <= fifo_mem[fifo_ra];
	end

	// An entry that was never written reads as its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_vld_q <= '0;
			cnt_vld_q  <= '0;
		end else begin
			if (mark_we) begin
				mark_vld_q[mark_wa] <= 1'b1;
			end
			if (cnt_we) begin
				cnt_vld_q[AW'(blk_q)] <= 1'b1;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= out_d;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			dcount_q    <= '0;
			lim_q       <= CW'(1);
			head_q      <= '0;
			push_pend_q <= 1'b0;
			idx_q       <= '0;
			op_q        <= OP_RD_FAULT;
			blk_q       <= '0;
			wr_q        <= 1'b0;
			m_q         <= MK_HOST;
			wfc_q       <= '0;
			ev_blk_q    <= '0;
			ev_m_q      <= MK_HOST;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_data.opcode;
						blk_q   <= in_data.block_index;
						wr_q    <= in_data.acquire_writable;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (32'(blk_q) >= NUM_BLOCKS) begin
						blk_q <= blk_q - NB_MOD;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					m_q     <= rd_mark;
					wfc_q   <= rd_cnt;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
						case (op_q)
							OP_WR_FAULT, OP_MAP: begin
								if (add) begin
									lim_q       <= lim_inc;
									push_pend_q <= full;
									state_q     <= full ? S_EV0 : S_PUSH;
								end
							end
							OP_RELEASE: begin
								if (m_q == MK_DIRTY) begin
									idx_q   <= '0;
									state_q <= S_RM0;
								end
							end
							OP_UNMAP: begin
								idx_q   <= '0;
								state_q <= S_RM0;
							end
							OP_REL_ALL: begin
								if (shrink) begin
									lim_q <= lim_q >> 1;
								end
								push_pend_q <= 1'b0;
								if (dcount_q != '0) begin
									state_q <= S_EV0;
								end
							end
							OP_RELD_ALL: begin
								if (shrink) begin
									lim_q <= lim_q >> 1;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_EV0: begin
					head_q   <= wrap_add(head_q, CW'(1));
					dcount_q <= dcount_q - CW'(1);
					state_q  <= S_EV1;
				end
				S_EV1: begin
					ev_blk_q <= fifo_rd_q;
					state_q  <= S_EV2;
				end
				S_EV2: begin
					ev_m_q  <= rd_mark;
					state_q <= S_EV3;
				end
				S_EV3: begin
					if (out_free) begin
						if (push_pend_q) begin
							push_pend_q <= 1'b0;
							state_q     <= S_PUSH;
						end else if (dcount_q > floor_c) begin
							state_q <= S_EV0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PUSH: begin
					dcount_q <= dcount_q + CW'(1);
					if (cfg.eager_mode &&
					    ((CW+1)'(dcount_q) + (CW+1)'(1) > (CW+1)'(lim_q))) begin
						state_q <= S_EV0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RM0: begin
					state_q <= (idx_q < dcount_q) ? S_RM1 : S_IDLE;
				end
				S_RM1: begin
					if (fifo_rd_q == blk_q) begin
						state_q <= S_SH0;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_RM0;
					end
				end
				S_SH0: begin
					if ((CW+1)'(idx_q) + (CW+1)'(1) < (CW+1)'(dcount_q)) begin
						state_q <= S_SH1;
					end else begin
						dcount_q <= dcount_q - CW'(1);
						state_q  <= S_IDLE;
					end
				end
				S_SH1: begin
					idx_q   <= idx_nxt;
					state_q <= S_SH0;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- dv/lazy_block_coherence_dirty_list_tb.sv -----
`timescale 1ns / 1ps
module lazy_block_coherence_dirty_list_tb;
	import lbcd_pkg::*;

	localparam int NBLK = 64;
	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	lbcd_in_t in_data;
	logic out_valid;
	logic out_ready;
	lbcd_out_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	// Shadow copy of the coherence tracker.
	logic [1:0] mark_shadow [NBLK];
	logic [7:0] wfault_shadow [NBLK];
	logic [5:0] dirty_list [$];
	int dirty_cap;
	logic eager_shadow;
	logic [7:0] thresh_shadow;

	lbcd_out_t pending_actions [$];
	lbcd_out_t expected_actions [$];

	int errors;
	int cycles;
	bit idle_on;
	bit hold_req;

	lazy_block_coherence_dirty_list dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [1:0] host_prot(logic [1:0] mk);
		if (mk == MK_INV) return PR_NONE;
		if (mk == MK_RO) return PR_READ;
		return PR_RW;
	endfunction

	function automatic void post(logic [1:0] act, logic [5:0] blk, logic [1:0] mk,
			logic [1:0] pr, logic err);
		lbcd_out_t r;
		r.action = act;
		r.target_block = blk;
		r.new_state = mk;
		r.protection = pr;
		r.error = err;
		r.last = 1'b0;
		pending_actions.push_back(r);
	endfunction

	function automatic void post_plain(logic [5:0] blk, logic err);
		post(ACT_NONE, blk, mark_shadow[blk], host_prot(mark_shadow[blk]), err);
	endfunction

	function automatic void evict_oldest();
		logic [5:0] b;
		if (dirty_list.size() == 0) return;
		b = dirty_list.pop_front();
		if (mark_shadow[b] == MK_DIRTY) begin
			mark_shadow[b] = MK_RO;
			post(ACT_TO_ACC, b, MK_RO, PR_READ, 1'b0);
		end else begin
			post_plain(b, 1'b0);
		end
	endfunction

	function automatic void list_dirty(logic [5:0] b);
		if (dirty_list.size() >= DEPTH) evict_oldest();
		dirty_list.push_back(b);
		if (!eager_shadow) return;
		if (wfault_shadow[b] >= thresh_shadow) begin
			wfault_shadow[b] = 8'd0;
			if (dirty_cap < DEPTH) dirty_cap++;
		end
		while (dirty_list.size() > dirty_cap) evict_oldest();
	endfunction

	function automatic void unlist(logic [5:0] b);
		for (int i = 0; i < dirty_list.size(); i++) begin
			if (dirty_list[i] == b) begin
				dirty_list.delete(i);
				return;
			end
		end
	endfunction

	function automatic void maybe_halve();
		if (eager_shadow && dirty_list.size() < dirty_cap && dirty_cap > 1)
			dirty_cap = dirty_cap / 2;
	endfunction

	// Works out the actions that one accepted transaction causes.
	function automatic void predict_actions(lbcd_in_t it);
		logic [5:0] b;
		logic [1:0] m;
		b = it.block_index;
		m = mark_shadow[b];
		pending_actions.delete();
		case (it.opcode)
			OP_RD_FAULT: begin
				if (m == MK_HOST) begin
					post(ACT_NONE, b, MK_HOST, PR_RW, 1'b0);
				end else if (m == MK_INV) begin
					mark_shadow[b] = MK_RO;
					post(ACT_TO_HOST, b, MK_RO, PR_READ, 1'b0);
				end else begin
					post(ACT_NONE, b, m, PR_READ, 1'b0);
				end
			end
			OP_WR_FAULT: begin
				if (wfault_shadow[b] != 8'hff) wfault_shadow[b]++;
				if (m == MK_DIRTY) begin
					post(ACT_NONE, b, MK_DIRTY, PR_RW, 1'b0);
				end else begin
					mark_shadow[b] = MK_DIRTY;
					post((m == MK_INV) ? ACT_TO_HOST : ACT_NONE, b, MK_DIRTY, PR_RW, 1'b0);
					list_dirty(b);
				end
			end
			OP_ACQUIRE: begin
				if ((m == MK_INV || m == MK_RO) && it.acquire_writable) begin
					mark_shadow[b] = MK_INV;
					post(ACT_NONE, b, MK_INV, PR_NONE, 1'b0);
				end else begin
					post_plain(b, 1'b0);
				end
			end
			OP_RELEASE: begin
				if (m == MK_DIRTY) begin
					mark_shadow[b] = MK_RO;
					unlist(b);
					post(ACT_TO_ACC, b, MK_RO, PR_READ, 1'b0);
				end else begin
					post_plain(b, 1'b0);
				end
			end
			OP_REL_ALL: begin
				maybe_halve();
				if (dirty_list.size() == 0) post_plain(b, 1'b0);
				while (dirty_list.size() > 0) evict_oldest();
			end
			OP_RELD_ALL: begin
				maybe_halve();
				post_plain(b, 1'b0);
			end
			OP_MAP: begin
				if (m == MK_HOST) begin
					mark_shadow[b] = MK_DIRTY;
					post(ACT_NONE, b, MK_DIRTY, PR_RW, 1'b0);
					list_dirty(b);
				end else begin
					post_plain(b, 1'b1);
				end
			end
			OP_UNMAP: begin
				mark_shadow[b] = MK_HOST;
				unlist(b);
				post((m == MK_INV) ? ACT_TO_HOST : ACT_NONE, b, MK_HOST, PR_RW, 1'b0);
			end
			OP_TO_HOST: begin
				if (m == MK_INV) begin
					mark_shadow[b] = MK_RO;
					post(ACT_TO_HOST, b, MK_RO, PR_READ, 1'b0);
				end else begin
					post_plain(b, 1'b0);
				end
			end
			default: post_plain(b, 1'b0);
		endcase
		pending_actions[pending_actions.size()-1].last = 1'b1;
		foreach (pending_actions[i]) expected_actions.push_back(pending_actions[i]);
	endfunction

	// Compare finished transactions first, then predict newly accepted ones.
	always @(posedge clk) begin
		lbcd_out_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_actions.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					e = expected_actions.pop_front();
					if (e !== out_data) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) predict_actions(in_data);
		end
	end

	// Guard against a hang.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_item(logic [3:0] op, logic [5:0] blk, logic wr);
		int gap;
		if (idle_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{opcode: op, block_index: blk, acquire_writable: wr};
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every expected transaction has come back.
	// The first edge lets the checker record the transaction accepted last.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_actions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [7:0] val);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_EAGER) eager_shadow = val[0];
		else thresh_shadow = val;
	endtask

	// Walk the marks through every operation and a set of corner cases.
	task automatic test_directed();
		send_item(OP_MAP, 6'd0, 1'b0);
		send_item(OP_MAP, 6'd0, 1'b1);
		send_item(OP_RD_FAULT, 6'd0, 1'b0);
		send_item(OP_RD_FAULT, 6'd63, 1'b0);
		send_item(OP_WR_FAULT, 6'd63, 1'b0);
		send_item(OP_RELEASE, 6'd0, 1'b0);
		send_item(OP_ACQUIRE, 6'd0, 1'b1);
		send_item(OP_RD_FAULT, 6'd0, 1'b0);
		send_item(OP_ACQUIRE, 6'd0, 1'b0);
		send_item(OP_WR_FAULT, 6'd0, 1'b0);
		send_item(OP_RELEASE, 6'd42, 1'b0);
		send_item(OP_ACQUIRE, 6'd0, 1'b1);
		send_item(OP_ACQUIRE, 6'd63, 1'b1);
		send_item(OP_TO_HOST, 6'd63, 1'b0);
		send_item(OP_TO_HOST, 6'd21, 1'b0);
		send_item(OP_UNMAP, 6'd0, 1'b0);
		send_item(OP_UNMAP, 6'd63, 1'b0);
		send_item(OP_WR_FAULT, 6'd21, 1'b0);
		send_item(OP_RELD_ALL, 6'd5, 1'b0);
		send_item(OP_REL_ALL, 6'd7, 1'b0);
		send_item(OP_REL_ALL, 6'd7, 1'b1);
		send_item(4'd9, 6'd42, 1'b1);
		send_item(4'd15, 6'd63, 1'b0);
		send_item(OP_WR_FAULT, 6'd0, 1'b0);
		drain();
	endtask

	// More dirty blocks than the list holds: the oldest ones are released.
	task automatic test_list_overflow();
		for (int i = 0; i < 36; i++) send_item(OP_WR_FAULT, 6'(i + 20), 1'b0);
		send_item(OP_REL_ALL, 6'd1, 1'b0);
		drain();
	endtask

	task automatic random_item(bit wide);
		logic [3:0] op;
		logic [5:0] blk;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) op = OP_WR_FAULT;
		else if (pick < 32) op = OP_RD_FAULT;
		else if (pick < 44) op = OP_MAP;
		else if (pick < 54) op = OP_RELEASE;
		else if (pick < 64) op = OP_ACQUIRE;
		else if (pick < 72) op = OP_UNMAP;
		else if (pick < 80) op = OP_TO_HOST;
		else if (pick < 86) op = OP_RELD_ALL;
		else if (pick < 90) op = OP_REL_ALL;
		else if (pick < 95) op = 4'($urandom_range(9, 15));
		else op = OP_WR_FAULT;
		blk = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
		send_item(op, blk, 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) random_item($urandom_range(0, 2) == 0);
		drain();
	endtask

	// Results are held back long enough for the block to stall its input.
	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++) random_item(1'b1);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycles = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		eager_shadow = 1'b0;
		thresh_shadow = 8'd2;
		dirty_cap = 1;
		for (int i = 0; i < NBLK; i++) begin
			mark_shadow[i] = MK_HOST;
			wfault_shadow[i] = 8'd0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_list_overflow();
		test_random(20);
		cfg_write(REG_EAGER, 8'd1);
		cfg_write(REG_THRESH, 8'd1);
		test_directed();
		test_random(25);
		test_backpressure();
		cfg_write(REG_THRESH, 8'd255);
		test_random(30);
		cfg_write(REG_EAGER, 8'd0);
		test_random(20);
		cfg_write(REG_EAGER, 8'd1);
		cfg_write(REG_THRESH, 8'd3);
		idle_on = 1'b0;
		test_random(40);

		drain();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
